@@ src/bsr_pkg.sv @@
`default_nettype none

package bsr_pkg;

    localparam int MAX_BITS    = 64;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_BYTE  = 2'd1,
        OP_END   = 2'd2,
        OP_FLUSH = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_COMPLETE = 2'd0,
        ST_SHORT    = 2'd1,
        ST_REJECTED = 2'd2
    } status_t;

    // One classified input transaction as it sits in the queue.
    typedef struct packed {
        op_t        op;
        logic [7:0] byte_value;
        logic [6:0] bit_count;
        logic       lsb_first;
        logic       count_ok;
    } item_t;

endpackage

`default_nettype wire

@@ src/bsr_front.sv @@
`default_nettype none

module bsr_front
    import bsr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  in_op,
    input  wire logic [7:0]  in_byte_value,
    input  wire logic [6:0]  in_bit_count,
    input  wire logic        in_lsb_first,
    output logic             head_valid,
    output item_t            head,
    input  wire logic        head_pop
);

    item_t                 queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]       count_reg, count_next;
    item_t                 new_item;
    logic                  push;
    logic                  pop;

    // Classify: decode the kind and check the requested bit count up front.
    always_comb
    begin
        new_item.op         = op_t'(in_op);
        new_item.byte_value = in_byte_value;
        new_item.bit_count  = in_bit_count;
        new_item.lsb_first  = in_lsb_first;
        new_item.count_ok   = (in_bit_count != 7'd0) && (in_bit_count <= 7'(MAX_BITS));
    end

    assign in_ready   = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = queue_reg[rd_ptr_reg];
    assign push       = in_valid && in_ready;
    assign pop        = head_pop && head_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ src/bsr_back.sv @@
`default_nettype none

module bsr_back
    import bsr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        head_valid,
    input  wire item_t       head,
    output logic             head_pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [63:0]      out_data,
    output logic [6:0]       out_bits_read,
    output status_t          out_status
);

    // Reader state
    logic [7:0]  held_reg, held_next;
    logic [3:0]  left_reg, left_next;
    logic        pend_reg, pend_next;
    logic [6:0]  want_reg, want_next;
    logic [6:0]  gath_reg, gath_next;
    logic        lsb_reg, lsb_next;
    logic [63:0] acc_reg, acc_next;
    logic        ended_reg, ended_next;

    // Result register
    logic        valid_reg, valid_next;
    logic [63:0] data_reg, data_next;
    logic [6:0]  bits_reg, bits_next;
    status_t     status_reg, status_next;

    // State after the op-specific update, before bits are taken
    logic [7:0]  p_held;
    logic [3:0]  p_left;
    logic        p_pend;
    logic [6:0]  p_want;
    logic [6:0]  p_gath;
    logic        p_lsb;
    logic [63:0] p_acc;
    logic        p_ended;
    logic        rejected;
    logic        check_done;

    // Bit placer
    logic [6:0]  remain;
    logic        take_en;
    logic [3:0]  n;
    logic [8:0]  mask_n9;
    logic [7:0]  mask_n;
    logic [7:0]  lsb_chunk;
    logic [7:0]  msb_chunk;
    logic [2:0]  k_lo;
    logic [2:0]  k_hi;
    logic [3:0]  room;
    logic [3:0]  part_a;
    logic [3:0]  part_b;
    logic [8:0]  mask_b9;
    logic [7:0]  old_byte;
    logic [7:0]  old_shifted;
    logic [7:0]  new_lo;
    logic [7:0]  new_hi;
    logic [63:0] t_acc;
    logic [3:0]  t_left;
    logic [6:0]  t_gath;

    logic        fire;
    logic        emit;

    assign fire     = head_valid && (!valid_reg || out_ready);
    assign head_pop = fire;

    always_comb
    begin
        p_held     = held_reg;
        p_left     = left_reg;
        p_pend     = pend_reg;
        p_want     = want_reg;
        p_gath     = gath_reg;
        p_lsb      = lsb_reg;
        p_acc      = acc_reg;
        p_ended    = ended_reg;
        rejected   = 1'b0;
        check_done = 1'b0;
        if (fire)
        begin
            unique case (head.op)
                OP_READ:
                begin
                    if (pend_reg || !head.count_ok)
                    begin
                        rejected = 1'b1;
                    end
                    else
                    begin
                        p_pend     = 1'b1;
                        p_want     = head.bit_count;
                        p_gath     = '0;
                        p_lsb      = head.lsb_first;
                        p_acc      = '0;
                        check_done = 1'b1;
                    end
                end
                OP_BYTE:
                begin
                    if (left_reg != 4'd0)
                    begin
                        rejected = 1'b1;
                    end
                    else
                    begin
                        p_held     = head.byte_value;
                        p_left     = 4'd8;
                        p_ended    = 1'b0;
                        check_done = 1'b1;
                    end
                end
                OP_END:
                begin
                    p_ended    = 1'b1;
                    check_done = 1'b1;
                end
                OP_FLUSH:
                begin
                    p_left = '0;
                end
            endcase
        end
    end

    // Place up to eight bits from the held byte at once.
    always_comb
    begin
        remain    = p_want - p_gath;
        take_en   = check_done && p_pend && (p_gath < p_want) && (p_left != 4'd0);
        n         = '0;
        if (take_en)
        begin
            n = (remain < {3'b000, p_left}) ? remain[3:0] : p_left;
        end
        mask_n9   = (9'd1 << n) - 9'd1;
        mask_n    = mask_n9[7:0];
        lsb_chunk = (p_held >> (4'd8 - p_left)) & mask_n;
        msb_chunk = (p_held >> (p_left - n)) & mask_n;

        // MSB first: split the chunk across the current and the next output byte
        k_lo        = p_gath[5:3];
        k_hi        = k_lo + 3'd1;
        room        = 4'd8 - {1'b0, p_gath[2:0]};
        part_a      = (n < room) ? n : room;
        part_b      = n - part_a;
        mask_b9     = (9'd1 << part_b) - 9'd1;
        old_byte    = 8'h00;
        for (int j = 0; j < 8; j++)
        begin
            if (3'(j) == k_lo)
            begin
                old_byte = p_acc[8*j +: 8];
            end
        end
        old_shifted = old_byte << part_a;
        new_lo      = old_shifted | (msb_chunk >> part_b);
        new_hi      = msb_chunk & mask_b9[7:0];

        t_acc = p_acc;
        if (take_en)
        begin
            if (p_lsb)
            begin
                t_acc = p_acc | ({56'd0, lsb_chunk} << p_gath[5:0]);
            end
            else
            begin
                for (int j = 0; j < 8; j++)
                begin
                    if (3'(j) == k_lo)
                    begin
                        t_acc[8*j +: 8] = new_lo;
                    end
                    else if ((part_b != 4'd0) && (3'(j) == k_hi))
                    begin
                        t_acc[8*j +: 8] = new_hi;
                    end
                end
            end
        end
        t_left = p_left - n;
        t_gath = p_gath + {3'b000, n};
    end

    // Finish check and result register
    always_comb
    begin
        held_next   = held_reg;
        left_next   = left_reg;
        pend_next   = pend_reg;
        want_next   = want_reg;
        gath_next   = gath_reg;
        lsb_next    = lsb_reg;
        acc_next    = acc_reg;
        ended_next  = ended_reg;
        emit        = 1'b0;
        data_next   = data_reg;
        bits_next   = bits_reg;
        status_next = status_reg;
        if (fire)
        begin
            held_next  = p_held;
            left_next  = t_left;
            pend_next  = p_pend;
            want_next  = p_want;
            gath_next  = t_gath;
            lsb_next   = p_lsb;
            acc_next   = t_acc;
            ended_next = p_ended;
            if (rejected)
            begin
                emit        = 1'b1;
                data_next   = '0;
                bits_next   = '0;
                status_next = ST_REJECTED;
            end
            else if (check_done && p_pend)
            begin
                priority if (t_gath >= p_want)
                begin
                    emit        = 1'b1;
                    pend_next   = 1'b0;
                    data_next   = t_acc;
                    bits_next   = t_gath;
                    status_next = ST_COMPLETE;
                end
                else if ((t_left == 4'd0) && p_ended)
                begin
                    emit        = 1'b1;
                    pend_next   = 1'b0;
                    data_next   = t_acc;
                    bits_next   = t_gath;
                    status_next = ST_SHORT;
                end
            end
        end
        if (valid_reg && !out_ready)
        begin
            valid_next = 1'b1;
        end
        else
        begin
            valid_next = emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= '0;
            left_reg  <= '0;
            pend_reg  <= 1'b0;
            want_reg  <= '0;
            gath_reg  <= '0;
            lsb_reg   <= 1'b0;
            acc_reg   <= '0;
            ended_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            held_reg  <= held_next;
            left_reg  <= left_next;
            pend_reg  <= pend_next;
            want_reg  <= want_next;
            gath_reg  <= gath_next;
            lsb_reg   <= lsb_next;
            acc_reg   <= acc_next;
            ended_reg <= ended_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            data_reg   <= data_next;
            bits_reg   <= bits_next;
            status_reg <= status_next;
        end
    end

    assign out_valid     = valid_reg;
    assign out_data      = data_reg;
    assign out_bits_read = bits_reg;
    assign out_status    = status_reg;

endmodule

`default_nettype wire

@@ src/bit_stream_reader.sv @@
`default_nettype none
// Bit stream reader.
// Slave channel (s_*): one transaction per command. s_tuser selects the kind:
// read request, stream byte, end of stream, or flush of the held bits.
// A read asks for 1..64 bits, LSB first or MSB first; stream bytes feed it.
// Master channel (m_*): at most one transaction per command, carrying the
// gathered bits, the delivered bit count and a status (complete, short at
// end of stream, rejected).
// Commands go into a 4-entry queue, then an executor that handles one
// command per cycle while results are taken, placing up to eight bits
// of the held byte at once. The queue and the result register lie between s_* and m_tvalid.
// Throughput: one command per cycle while the master side takes results.
// When the receiver stalls, the result register holds and the executor
// waits; the queue keeps taking commands until its four entries are full,
// then s_tready drops.
// Reset clears the queue, the reader state (held byte, pending request,
// end-of-stream flag) and the result valid; no result is pending after it.

module bit_stream_reader
    import bsr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // byte_value[7:0], bit_count[14:8], lsb_first[15]
    input  wire logic [1:0]  s_tuser,   // op[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // data[63:0], bits_read[70:64], zero[71]
    output logic [1:0]       m_tuser    // status[1:0]
);

    logic        head_valid;
    item_t       head;
    logic        head_pop;
    logic [63:0] res_data;
    logic [6:0]  res_bits;
    status_t     res_status;

    // Front: classify each transaction and queue it.
    bsr_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_op         (s_tuser),
        .in_byte_value (s_tdata[7:0]),
        .in_bit_count  (s_tdata[14:8]),
        .in_lsb_first  (s_tdata[15]),
        .head_valid    (head_valid),
        .head          (head),
        .head_pop      (head_pop)
    );

    // Back: advance the reader state and register the result.
    bsr_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head          (head),
        .head_pop      (head_pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_data      (res_data),
        .out_bits_read (res_bits),
        .out_status    (res_status)
    );

    assign m_tdata = {1'b0, res_bits, res_data};
    assign m_tuser = res_status;

`ifndef SYNTH
    // Rejected transactions carry no bits.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == ST_REJECTED)) |-> (m_tdata == 72'd0))
        else $error("rejected result carries data");

    // The bit count never exceeds the largest request.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[70:64] <= 7'(MAX_BITS)))
        else $error("bits_read above maximum");

    // A complete result delivers at least one bit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == ST_COMPLETE)) |-> (m_tdata[70:64] != 7'd0))
        else $error("complete result with zero bits");

    // Status code three is never produced.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser != 2'd3))
        else $error("undefined status code");
`endif

endmodule

`default_nettype wire
